>>> hw/rtl/irkb_pkg.sv
// Shared types, constants and helpers for the IR keyboard pulse decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package irkb_pkg;

  localparam int DUR_W          = 11;
  localparam int CNT_W          = 4;
  localparam int POS_FULL_W     = 12;
  localparam int KEY_W          = 20;
  localparam int ADDR_W         = 5;
  localparam int DATA_W         = 32;
  localparam int FRAME_BITS_DEF = 22;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [CNT_W-1:0] FIFO_INVALID = 4'hf;
  localparam logic [31:0]      FRAME_MASK   = 32'h0020_0508;
  localparam int               KEY_LSB      = 12;
  localparam int               RELEASE_BIT  = 7;

  // register indexes (word address)
  localparam logic [2:0] REG_ZERO_MIN = 3'd0;
  localparam logic [2:0] REG_ZERO_NOM = 3'd1;
  localparam logic [2:0] REG_ZERO_MAX = 3'd2;
  localparam logic [2:0] REG_ONE_MIN  = 3'd3;
  localparam logic [2:0] REG_ONE_NOM  = 3'd4;
  localparam logic [2:0] REG_ONE_MAX  = 3'd5;

  localparam logic [DUR_W-1:0] ZERO_MIN_RST = 11'd42;
  localparam logic [DUR_W-1:0] ZERO_NOM_RST = 11'd48;
  localparam logic [DUR_W-1:0] ZERO_MAX_RST = 11'd61;
  localparam logic [DUR_W-1:0] ONE_MIN_RST  = 11'd28;
  localparam logic [DUR_W-1:0] ONE_NOM_RST  = 11'd43;
  localparam logic [DUR_W-1:0] ONE_MAX_RST  = 11'd56;

  typedef struct packed {
    logic [DUR_W-1:0] min_t;
    logic [DUR_W-1:0] nom_t;
    logic [DUR_W-1:0] max_t;
  } irkb_lim_t;

  typedef struct packed {
    irkb_lim_t zero;
    irkb_lim_t one;
  } irkb_cfg_t;

  // classified transition waiting for the back end
  typedef struct packed {
    logic             level;
    logic             long_run;
    logic [DUR_W-1:0] duration;
  } irkb_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_APPLY
  } irkb_state_e;

  // n low ones, n in 0..63; any n of 32 or more gives all ones
  function automatic logic [31:0] low_mask(input logic [5:0] n);
    logic [31:0] m;
    if (n >= 6'd32) begin
      m = '1;
    end else begin
      m = (32'h1 << n) - 32'h1;
    end
    return m;
  endfunction

endpackage

>>> hw/rtl/irkb_regs.sv
// Configuration registers (bit window limits per level) behind an APB-style port.
// Depends on irkb_pkg.
`timescale 1ns / 1ps

module irkb_regs
  import irkb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output irkb_cfg_t         cfg_o
);

  irkb_cfg_t        cfg_q, cfg_d;
  logic [2:0]       idx;
  logic [DUR_W-1:0] wval;
  logic [DUR_W-1:0] rval;

  assign idx    = paddr[ADDR_W-1:2];
  assign wval   = pwdata[DUR_W-1:0];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (idx)
        REG_ZERO_MIN: cfg_d.zero.min_t = wval;
        REG_ZERO_NOM: cfg_d.zero.nom_t = wval;
        REG_ZERO_MAX: cfg_d.zero.max_t = wval;
        REG_ONE_MIN:  cfg_d.one.min_t  = wval;
        REG_ONE_NOM:  cfg_d.one.nom_t  = wval;
        REG_ONE_MAX:  cfg_d.one.max_t  = wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ZERO_MIN: rval = cfg_q.zero.min_t;
      REG_ZERO_NOM: rval = cfg_q.zero.nom_t;
      REG_ZERO_MAX: rval = cfg_q.zero.max_t;
      REG_ONE_MIN:  rval = cfg_q.one.min_t;
      REG_ONE_NOM:  rval = cfg_q.one.nom_t;
      REG_ONE_MAX:  rval = cfg_q.one.max_t;
      default:      rval = '0;
    endcase
  end

  assign prdata = {{(DATA_W-DUR_W){1'b0}}, rval};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero.min_t <= ZERO_MIN_RST;
      cfg_q.zero.nom_t <= ZERO_NOM_RST;
      cfg_q.zero.max_t <= ZERO_MAX_RST;
      cfg_q.one.min_t  <= ONE_MIN_RST;
      cfg_q.one.nom_t  <= ONE_NOM_RST;
      cfg_q.one.max_t  <= ONE_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> hw/rtl/irkb_front.sv
// Front end: accepts transitions, drops invalid ones, flags long runs and
// queues the rest for the back end. Depends on irkb_pkg.
`timescale 1ns / 1ps

module irkb_front
  import irkb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  irkb_cfg_t        cfg_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CNT_W-1:0] fifo_count_i,
  input  logic             level_i,
  input  logic [DUR_W-1:0] duration_i,
  output logic             q_valid_o,
  output irkb_entry_t      q_entry_o,
  input  logic             q_pop_i
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  irkb_entry_t      mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [OCC_W-1:0] occ_q;

  irkb_lim_t        lim;
  logic [DUR_W:0]   two_min;
  logic             win_ok;
  logic             accept;
  logic             push;
  logic             pop;
  logic             full;

  assign lim     = level_i ? cfg_i.one : cfg_i.zero;
  assign two_min = {lim.min_t, 1'b0};
  // window: min <= t and (t <= max or t >= 2*min)
  assign win_ok  = (duration_i >= lim.min_t) &&
                   ((duration_i <= lim.max_t) || ({1'b0, duration_i} >= two_min));

  assign full       = (occ_q == OCC_W'(QUEUE_DEPTH));
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;
  assign push       = accept && (fifo_count_i != FIFO_INVALID) && win_ok;
  assign pop        = q_pop_i && (occ_q != '0);

  assign q_valid_o  = (occ_q != '0);
  assign q_entry_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{level: level_i,
                           long_run: (duration_i > lim.max_t),
                           duration: duration_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      occ_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   occ_q <= occ_q + 1'b1;
        2'b01:   occ_q <= occ_q - 1'b1;
        default: occ_q <= occ_q;
      endcase
    end
  end

endmodule

>>> hw/rtl/irkb_back.sv
// Back end: serial divider for long runs, bit packing into the frame word,
// frame completion with carry-over, and the output register. Depends on irkb_pkg.
`timescale 1ns / 1ps

module irkb_back
  import irkb_pkg::*;
#(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  irkb_cfg_t        cfg_i,
  input  logic             q_valid_i,
  input  irkb_entry_t      q_entry_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             frame_ok_o,
  output logic [KEY_W-1:0] key_field_o,
  output logic             key_released_o
);

  localparam int POS_W  = $clog2(FRAME_BITS);
  localparam int STEP_W = $clog2(DUR_W + 1);
  localparam logic [POS_FULL_W-1:0] FB = POS_FULL_W'(FRAME_BITS);

  irkb_state_e       state_q, state_d;
  logic              lvl_q, lvl_d;
  logic [DUR_W-1:0]  div_d_q, div_d_d;   // divisor
  logic [DUR_W-1:0]  quo_q, quo_d;       // dividend shifts out, quotient shifts in
  logic [DUR_W-1:0]  rem_q, rem_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [31:0]       word_q, word_d;
  logic              out_valid_q, out_valid_d;
  logic              frame_ok_q, frame_ok_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic              rel_q, rel_d;

  logic [DUR_W:0]          trial;
  logic                    ge;
  logic [POS_FULL_W-1:0]   newpos;
  logic [5:0]              hi;
  logic [31:0]             run;
  logic [31:0]             word_full;
  logic                    complete;
  logic                    carry;
  logic [POS_W-1:0]        carry_pos;
  logic                    out_free;

  // restoring step; a zero divisor yields all ones in the quotient
  assign trial = {rem_q, quo_q[DUR_W-1]};
  assign ge    = (trial >= {1'b0, div_d_q});

  // quo_q holds the bit count once ST_APPLY is reached
  assign newpos    = {{(POS_FULL_W-POS_W){1'b0}}, pos_q} + {1'b0, quo_q};
  assign hi        = (newpos >= POS_FULL_W'(32)) ? 6'd32 : newpos[5:0];
  assign run       = lvl_q ? (low_mask(hi) & ~low_mask(6'(pos_q))) : '0;
  assign word_full = word_q | run;
  assign complete  = (newpos >= FB);
  assign carry     = ({1'b0, quo_q} < FB) && (newpos > FB);
  assign carry_pos = POS_W'(newpos - FB);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    lvl_d       = lvl_q;
    div_d_d     = div_d_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    step_d      = step_q;
    pos_d       = pos_q;
    word_d      = word_q;
    frame_ok_d  = frame_ok_q;
    key_d       = key_q;
    rel_d       = rel_q;
    out_valid_d = out_valid_q && out_stall_i;
    q_pop_o     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          lvl_d   = q_entry_i.level;
          div_d_d = q_entry_i.level ? cfg_i.one.nom_t : cfg_i.zero.nom_t;
          rem_d   = '0;
          step_d  = '0;
          if (q_entry_i.long_run) begin
            quo_d   = q_entry_i.duration;
            state_d = ST_DIV;
          end else begin
            quo_d   = DUR_W'(1);
            state_d = ST_APPLY;
          end
        end
      end
      ST_DIV: begin
        rem_d  = ge ? DUR_W'(trial - {1'b0, div_d_q}) : trial[DUR_W-1:0];
        quo_d  = {quo_q[DUR_W-2:0], ge};
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DUR_W - 1)) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (!complete) begin
          pos_d   = POS_W'(newpos);
          word_d  = word_full;
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          frame_ok_d  = ((word_full & FRAME_MASK) == FRAME_MASK);
          key_d       = word_full[31:KEY_LSB];
          rel_d       = word_full[RELEASE_BIT];
          if (carry) begin
            pos_d  = carry_pos;
            word_d = lvl_q ? low_mask(6'(carry_pos)) : '0;
          end else begin
            pos_d  = '0;
            word_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      word_q      <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      word_q      <= word_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q      <= lvl_d;
    div_d_q    <= div_d_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    frame_ok_q <= frame_ok_d;
    key_q      <= key_d;
    rel_q      <= rel_d;
  end

  assign out_valid_o    = out_valid_q;
  assign frame_ok_o     = frame_ok_q;
  assign key_field_o    = key_q;
  assign key_released_o = rel_q;

  // position never reaches a full frame between items
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {{(POS_FULL_W-POS_W){1'b0}}, pos_q} < FB)
    else $error("bit position reached frame length");

  // no word bits set at or above the current position
  a_word_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word_q & ~low_mask(6'(pos_q))) == '0)
    else $error("frame word has bits beyond position");

  // a new result only comes out of the apply step
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_APPLY))
    else $error("result raised outside apply");

  // divider runs exactly DUR_W steps
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (step_q < STEP_W'(DUR_W)))
    else $error("divider overran");

  // queue pops only when the back end is free
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == ST_IDLE) && q_valid_i)
    else $error("pop while busy");

endmodule

>>> hw/rtl/ir_keyboard_pulse_decoder_top.sv
// IR keyboard pulse decoder, top level: register file, front end and back end.
// Depends on irkb_pkg, irkb_regs, irkb_front and irkb_back.
`timescale 1ns / 1ps

// Each accepted word is one IR transition (FIFO count, level, duration). Count 15
// and durations outside the level's window are dropped in the front end; the rest
// wait in a two-entry queue, so input is taken while the back end works or a
// result is stalled. In the back end a single-bit transition goes from idle to
// apply; a long run passes the 11-step serial divider for duration / nominal time
// first. A finished frame is held in the output register until taken; the back
// end waits there only if a second frame completes meanwhile.
// Limits are written through the APB-style port at byte address 4*index.
module ir_keyboard_pulse_decoder_top
  import irkb_pkg::*;
#(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CNT_W-1:0]  fifo_count_i,
  input  logic              level_i,
  input  logic [DUR_W-1:0]  duration_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              frame_ok_o,
  output logic [KEY_W-1:0]  key_field_o,
  output logic              key_released_o
);

  irkb_cfg_t   cfg;
  logic        q_valid;
  irkb_entry_t q_entry;
  logic        q_pop;

  irkb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  irkb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .fifo_count_i (fifo_count_i),
    .level_i      (level_i),
    .duration_i   (duration_i),
    .q_valid_o    (q_valid),
    .q_entry_o    (q_entry),
    .q_pop_i      (q_pop)
  );

  irkb_back #(
    .FRAME_BITS (FRAME_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .q_valid_i      (q_valid),
    .q_entry_i      (q_entry),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_ok_o     (frame_ok_o),
    .key_field_o    (key_field_o),
    .key_released_o (key_released_o)
  );

endmodule
